// ===== design/mlh_pkg.sv =====
// shared types and codes for the monotone line hull block
package mlh_pkg;

  typedef logic signed [32:0] coef_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_QUERY_OK = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] ACT_ADD_HI = 2'd0;
  localparam logic [1:0] ACT_ADD_LO = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  typedef enum logic [2:0] {
    RD_END,
    RD_SECOND,
    RD_QM1,
    RD_QM,
    RD_QLO
  } rd_sel_t;

  typedef struct packed {
    logic       accept;
    rd_sel_t    rd_sel;
    logic       cap_e1;
    logic       cap_e2;
    logic       shift_e;
    logic       mul_ev;
    logic       mul_q;
    logic       ld_p1;
    logic       ld_p2;
    logic       pop;
    logic       wr_line;
    logic       q_init;
    logic       q_step;
    logic       q_fin;
    logic       ld_out;
    logic [2:0] st_code;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_gt1;
    logic full;
    logic dup_better;
    logic dup_eq;
    logic eq_lm;
    logic eq_hm;
    logic p_lt_q;
    logic q_more;
    logic q_ge;
  } dstat_t;

endpackage

// ===== design/mlh_ram.sv =====
// generic single-write, single-read ram with registered read data
module mlh_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mlh_datapath.sv =====
// datapath: line store, end pointers, shared multiplier, search bounds, result registers
module mlh_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mlh_pkg::cmd_t                cmd,
  output mlh_pkg::dstat_t              dstat,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic [1:0]                   in_action,
  input  logic signed [31:0]           in_slope,
  input  logic signed [31:0]           in_intercept,
  input  logic signed [31:0]           in_query_x,
  output logic [2:0]                   out_status,
  output logic signed [63:0]           out_best_value,
  output logic signed [31:0]           out_best_slope,
  output logic signed [31:0]           out_best_intercept,
  output logic [$clog2(DEPTH+1)-1:0]   out_lines_held
);
  import mlh_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic               mode_r;
  logic               back_r, neg_r;
  line_t              nl_r, e1_r, e2_r;
  logic signed [31:0] x_r;
  logic signed [67:0] p1_r, p2_r;
  logic signed [63:0] res_r;
  logic [CW-1:0]      lo_r, hi_r, count_r;
  logic [AW-1:0]      front_r;

  logic [2:0]         ost_r;
  logic signed [63:0] oval_r;
  logic signed [31:0] oslope_r, oicpt_r;
  logic [CW-1:0]      olines_r;

  logic [LINE_W-1:0]  rd_raw;
  line_t              rd_line, lo_l, mid_l, hi_l;
  logic [AW-1:0]      raddr, waddr, front_dec;
  logic [CW:0]        msum;
  logic [CW-1:0]      m;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [63:0] v1, v2;
  logic signed [32:0] s_slope, s_icpt, o_sa, o_sb;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(i);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [32:0] v);
    return {v[32], v};
  endfunction

  assign rd_line   = line_t'(rd_raw);
  assign msum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign m         = msum[CW:1];
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_END:    raddr = back_r ? slot_of(front_r, count_r - CW'(1)) : front_r;
      RD_SECOND: raddr = back_r ? slot_of(front_r, count_r - CW'(2))
                                : slot_of(front_r, CW'(1));
      RD_QM1:    raddr = slot_of(front_r, m - CW'(1));
      RD_QM:     raddr = slot_of(front_r, m);
      RD_QLO:    raddr = slot_of(front_r, lo_r);
      default:   raddr = front_r;
    endcase
  end

  assign waddr = back_r ? slot_of(front_r, count_r) : front_dec;

  mlh_ram #(.WIDTH(LINE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.wr_line),
    .waddr (waddr),
    .wdata (nl_r),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  // lo / mid / hi of the redundancy test, by end
  assign lo_l  = back_r ? e2_r : nl_r;
  assign mid_l = e1_r;
  assign hi_l  = back_r ? nl_r : e2_r;

  always_comb begin
    if (cmd.mul_ev) begin
      ma = sx34(rd_line.a);
      mb = {{2{x_r[31]}}, x_r};
    end else if (cmd.mul_q) begin
      ma = sx34(mid_l.a) - sx34(lo_l.a);
      mb = sx34(hi_l.b) - sx34(mid_l.b);
    end else begin
      ma = sx34(hi_l.a) - sx34(mid_l.a);
      mb = sx34(mid_l.b) - sx34(lo_l.b);
    end
  end

  assign prod = ma * mb;
  assign v1   = p1_r[63:0] + {{31{e1_r.b[32]}}, e1_r.b};
  assign v2   = p2_r[63:0] + {{31{e2_r.b[32]}}, e2_r.b};

  always_comb begin
    dstat.cnt_zero   = (count_r == '0);
    dstat.cnt_gt1    = (count_r > CW'(1));
    dstat.full       = (count_r == CW'(DEPTH));
    dstat.dup_eq     = (rd_line.a == nl_r.a);
    dstat.dup_better = (rd_line.a == nl_r.a) && (nl_r.b >= rd_line.b);
    dstat.eq_lm      = (lo_l.a == mid_l.a);
    dstat.eq_hm      = (hi_l.a == mid_l.a);
    dstat.p_lt_q     = (p1_r < p2_r);
    dstat.q_more     = ((hi_r - lo_r) > CW'(1));
    dstat.q_ge       = (v1 >= v2);
  end

  assign s_slope = {in_slope[31], in_slope};
  assign s_icpt  = {in_intercept[31], in_intercept};
  assign o_sa    = neg_r ? -e1_r.a : e1_r.a;
  assign o_sb    = neg_r ? -e1_r.b : e1_r.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      count_r <= '0;
      front_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.pop) begin
        count_r <= count_r - CW'(1);
        if (!back_r) begin
          front_r <= slot_of(front_r, CW'(1));
        end
      end else if (cmd.wr_line) begin
        count_r <= count_r + CW'(1);
        if (!back_r) begin
          front_r <= front_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      back_r <= ((in_action == ACT_ADD_HI) == mode_r);
      neg_r  <= !mode_r;
      nl_r.a <= mode_r ? s_slope : -s_slope;
      nl_r.b <= mode_r ? s_icpt : -s_icpt;
      x_r    <= in_query_x;
    end
    if (cmd.cap_e1) begin
      e1_r <= rd_line;
    end else if (cmd.shift_e) begin
      e1_r <= e2_r;
    end
    if (cmd.cap_e2) begin
      e2_r <= rd_line;
    end
    if (cmd.ld_p1) begin
      p1_r <= prod;
    end
    if (cmd.ld_p2) begin
      p2_r <= prod;
    end
    if (cmd.q_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd.q_step) begin
      if (dstat.q_ge) begin
        lo_r <= m;
      end else begin
        hi_r <= m;
      end
    end
    if (cmd.q_fin) begin
      res_r <= v1;
    end
    if (cmd.ld_out) begin
      ost_r    <= cmd.st_code;
      olines_r <= count_r;
      if (cmd.st_code == ST_QUERY_OK) begin
        oval_r   <= neg_r ? -res_r : res_r;
        oslope_r <= o_sa[31:0];
        oicpt_r  <= o_sb[31:0];
      end else begin
        oval_r   <= '0;
        oslope_r <= '0;
        oicpt_r  <= '0;
      end
    end
  end

  assign out_status         = ost_r;
  assign out_best_value     = oval_r;
  assign out_best_slope     = oslope_r;
  assign out_best_intercept = oicpt_r;
  assign out_lines_held     = olines_r;

endmodule

// ===== design/mlh_ctrl.sv =====
// controller: sequences adds, pops and the query search, owns the output handshake
module mlh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_action,
  output logic             out_valid,
  input  logic             out_ready,
  input  mlh_pkg::dstat_t  dstat,
  output mlh_pkg::cmd_t    cmd
);
  import mlh_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE       = 18'd1,
    S_RD_E1      = 18'd2,
    S_CHK_E1     = 18'd4,
    S_LOOP_START = 18'd8,
    S_CAP_E1     = 18'd16,
    S_LOOP_E2    = 18'd32,
    S_CAP_E2     = 18'd64,
    S_MUL_P      = 18'd128,
    S_MUL_Q      = 18'd256,
    S_CMP        = 18'd512,
    S_WRITE      = 18'd1024,
    S_Q_TEST     = 18'd2048,
    S_Q_RD2      = 18'd4096,
    S_Q_EV2      = 18'd8192,
    S_Q_CMP      = 18'd16384,
    S_Q_FIN_MUL  = 18'd32768,
    S_Q_FIN      = 18'd65536,
    S_DONE       = 18'd131072
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.rd_sel = RD_END;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!in_action[1]) begin
            state_nxt = dstat.cnt_zero ? S_WRITE : S_RD_E1;
          end else if (dstat.cnt_zero) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            cmd.q_init = 1'b1;
            state_nxt  = S_Q_TEST;
          end
        end
      end
      S_RD_E1: begin
        cmd.rd_sel = RD_END;
        state_nxt  = S_CHK_E1;
      end
      S_CHK_E1: begin
        cmd.cap_e1 = 1'b1;
        if (dstat.dup_better) begin
          st_nxt    = ST_DROPPED;
          state_nxt = S_DONE;
        end else if (dstat.full) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else if (dstat.dup_eq) begin
          cmd.pop   = 1'b1;
          state_nxt = S_LOOP_START;
        end else begin
          state_nxt = S_LOOP_E2;
        end
      end
      S_LOOP_START: begin
        if (dstat.cnt_gt1) begin
          cmd.rd_sel = RD_END;
          state_nxt  = S_CAP_E1;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_CAP_E1: begin
        cmd.cap_e1 = 1'b1;
        state_nxt  = S_LOOP_E2;
      end
      S_LOOP_E2: begin
        if (dstat.cnt_gt1) begin
          cmd.rd_sel = RD_SECOND;
          state_nxt  = S_CAP_E2;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_CAP_E2: begin
        cmd.cap_e2 = 1'b1;
        state_nxt  = S_MUL_P;
      end
      S_MUL_P: begin
        if (dstat.eq_lm) begin
          cmd.pop     = 1'b1;
          cmd.shift_e = 1'b1;
          state_nxt   = S_LOOP_E2;
        end else if (dstat.eq_hm) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.ld_p1 = 1'b1;
          state_nxt = S_MUL_Q;
        end
      end
      S_MUL_Q: begin
        cmd.mul_q = 1'b1;
        cmd.ld_p2 = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (dstat.p_lt_q) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.pop     = 1'b1;
          cmd.shift_e = 1'b1;
          state_nxt   = S_LOOP_E2;
        end
      end
      S_WRITE: begin
        cmd.wr_line = 1'b1;
        st_nxt      = ST_ADDED;
        state_nxt   = S_DONE;
      end
      S_Q_TEST: begin
        if (dstat.q_more) begin
          cmd.rd_sel = RD_QM1;
          state_nxt  = S_Q_RD2;
        end else begin
          cmd.rd_sel = RD_QLO;
          state_nxt  = S_Q_FIN_MUL;
        end
      end
      S_Q_RD2: begin
        cmd.rd_sel = RD_QM;
        cmd.mul_ev = 1'b1;
        cmd.ld_p1  = 1'b1;
        cmd.cap_e1 = 1'b1;
        state_nxt  = S_Q_EV2;
      end
      S_Q_EV2: begin
        cmd.mul_ev = 1'b1;
        cmd.ld_p2  = 1'b1;
        cmd.cap_e2 = 1'b1;
        state_nxt  = S_Q_CMP;
      end
      S_Q_CMP: begin
        cmd.q_step = 1'b1;
        state_nxt  = S_Q_TEST;
      end
      S_Q_FIN_MUL: begin
        cmd.mul_ev = 1'b1;
        cmd.ld_p1  = 1'b1;
        cmd.cap_e1 = 1'b1;
        state_nxt  = S_Q_FIN;
      end
      S_Q_FIN: begin
        cmd.q_fin = 1'b1;
        st_nxt    = ST_QUERY_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.st_code = st_r;
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.ld_out) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      st_r     <= ST_ADDED;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      st_r     <= st_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

endmodule

// ===== design/monotone_line_hull_min_query.sv =====
// top level of the monotone-slope line hull with envelope query
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_action, in_slope, in_intercept, in_query_x
//  out      output     out_valid / out_ready out_status, out_best_*, out_lines_held
//  cfg      input      cfg_wr_en             cfg_wr_data (min_mode)
//
// one transaction at a time; each step of the query's binary search does two store reads
// and two multiplies; a query on an empty store ends without a search
// an add on an empty store is written directly; otherwise the end line is read and the add
// is dropped if that line is no worse at equal slope, else redundant lines are popped first
// sync active-low reset empties the store at once (count and front index), min_mode = 1
// a finished result waits in the output register; the next transaction is taken meanwhile
// and only its own finish stalls on out_ready
module monotone_line_hull_min_query #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_action,
  input  logic signed [31:0]         in_slope,
  input  logic signed [31:0]         in_intercept,
  input  logic signed [31:0]         in_query_x,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic signed [63:0]         out_best_value,
  output logic signed [31:0]         out_best_slope,
  output logic signed [31:0]         out_best_intercept,
  output logic [$clog2(DEPTH+1)-1:0] out_lines_held
);
  import mlh_pkg::*;

  // command and status between sequencer and datapath
  cmd_t   cmd;
  dstat_t dstat;

  // sequencer: add, pop loop, binary search, output handoff
  mlh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dstat     (dstat),
    .cmd       (cmd)
  );

  // store, circular pointers, shared 34x34 multiplier, result registers
  mlh_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .dstat              (dstat),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_action          (in_action),
    .in_slope           (in_slope),
    .in_intercept       (in_intercept),
    .in_query_x         (in_query_x),
    .out_status         (out_status),
    .out_best_value     (out_best_value),
    .out_best_slope     (out_best_slope),
    .out_best_intercept (out_best_intercept),
    .out_lines_held     (out_lines_held)
  );

`ifndef ASSERT_OFF
  // store never reports more lines than its depth
  a_lines_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lines_held <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("lines_held beyond depth");

  // only successful queries carry a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_QUERY_OK)) |->
      ((out_best_value == '0) && (out_best_slope == '0) && (out_best_intercept == '0)))
    else $error("nonzero payload on non-query status");

  // empty-store query implies nothing held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_lines_held == '0))
    else $error("empty status with lines held");

  // no input taken while a transaction is in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");
`endif

endmodule
